>>> hdl/dfq_pkg.sv
`timescale 1ns / 1ps
// dfq_pkg: shared types and constants of the deadline FIFO queue.
// No dependencies.
package dfq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned TimeWidth    = 16;

  typedef logic [TimeWidth-1:0] time_t;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_LIST    = 3'd3,
    KIND_DELIVER = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_FULL      = 4'd1,
    ST_EMPTY     = 4'd2,
    ST_POPPED    = 4'd3,
    ST_HEAD      = 4'd4,
    ST_LISTED    = 4'd5,
    ST_DELIVERED = 4'd6,
    ST_EXPIRED   = 4'd7,
    ST_NONE_LEFT = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_EVAL
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] package_id;
    logic [15:0] destination_tag;
    time_t       window_start;
    time_t       window_end;
    time_t       now_time;
  } dfq_in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_id;
    logic [15:0] out_destination;
    time_t       out_start;
    time_t       out_end;
    logic        last_result;
  } dfq_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] dest;
    time_t       start;
    time_t       stop;
  } dfq_entry_t;

endpackage

>>> hdl/dfq_mem.sv
`timescale 1ns / 1ps
// dfq_mem: entry store, one write port and one read port, registered read.
// Depends on dfq_pkg.
module dfq_mem #(
  parameter int unsigned DEPTH = dfq_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  dfq_pkg::dfq_entry_t      wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output dfq_pkg::dfq_entry_t      rdata_o
);
  import dfq_pkg::*;

  dfq_entry_t mem_q [DEPTH];
  dfq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dfq_ctrl.sv
`timescale 1ns / 1ps
// dfq_ctrl: queue pointers, operation sequencer and output register.
// Depends on dfq_pkg; drives the ports of dfq_mem.
module dfq_ctrl #(
  parameter int unsigned DEPTH = dfq_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dfq_pkg::dfq_in_t         in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output dfq_pkg::dfq_out_t        out_word_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output dfq_pkg::dfq_entry_t      mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  dfq_pkg::dfq_entry_t      mem_rdata_i
);
  import dfq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  function automatic idx_t next_slot(idx_t s);
    return (s == idx_t'(DEPTH - 1)) ? '0 : s + idx_t'(1);
  endfunction

  state_e   state_q, state_d;
  dfq_in_t  req_q, req_d;
  idx_t     head_q, head_d;
  idx_t     tail_q, tail_d;
  idx_t     slot_q, slot_d;
  cnt_t     count_q, count_d;
  cnt_t     rem_q, rem_d;
  status_e  resp_q, resp_d;
  logic     out_valid_q, out_valid_d;
  dfq_out_t out_q, out_d;

  logic in_acc, out_free, empty, full, hit;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign empty    = (count_q == '0);
  assign full     = (count_q == cnt_t'(DEPTH));
  assign hit      = (req_q.now_time >= mem_rdata_i.start) &&
                    (req_q.now_time <= mem_rdata_i.stop);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_word_i.kind)
            KIND_PUSH: state_d = S_RESP;
            KIND_POP, KIND_PEEK, KIND_LIST, KIND_DELIVER:
              state_d = empty ? S_RESP : S_EVAL;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_EVAL: begin
        if (out_free) begin
          unique case (req_q.kind)
            KIND_LIST: state_d = (rem_q == cnt_t'(1)) ? S_IDLE : S_EVAL;
            KIND_DELIVER: begin
              if (hit) state_d = S_IDLE;
              else if (count_q == cnt_t'(1)) state_d = S_RESP;
              else state_d = S_EVAL;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    head_d      = head_q;
    tail_d      = tail_q;
    slot_d      = slot_q;
    count_d     = count_q;
    rem_d       = rem_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = '{id: req_q.package_id, dest: req_q.destination_tag,
                    start: req_q.window_start, stop: req_q.window_end};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d    = in_word_i;
          mem_re_o = 1'b1;
          slot_d   = next_slot(head_q);
          rem_d    = count_q;
          if (in_word_i.kind == KIND_PUSH) resp_d = full ? ST_FULL : ST_ADDED;
          else if (in_word_i.kind == KIND_DELIVER) resp_d = ST_NONE_LEFT;
          else resp_d = ST_EMPTY;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status      = resp_q;
          out_d.last_result = 1'b1;
          if (resp_q == ST_ADDED || resp_q == ST_FULL) begin
            out_d.out_id          = req_q.package_id;
            out_d.out_destination = req_q.destination_tag;
            out_d.out_start       = req_q.window_start;
            out_d.out_end         = req_q.window_end;
          end else begin
            out_d.out_id          = '0;
            out_d.out_destination = '0;
            out_d.out_start       = '0;
            out_d.out_end         = '0;
          end
          if (resp_q == ST_ADDED) begin
            mem_we_o = 1'b1;
            tail_d   = next_slot(tail_q);
            count_d  = count_q + cnt_t'(1);
          end
        end
      end
      S_EVAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.out_id          = mem_rdata_i.id;
          out_d.out_destination = mem_rdata_i.dest;
          out_d.out_start       = mem_rdata_i.start;
          out_d.out_end         = mem_rdata_i.stop;
          out_d.last_result     = 1'b1;
          out_d.status          = ST_HEAD;
          unique case (req_q.kind)
            KIND_POP: begin
              out_d.status = ST_POPPED;
              head_d  = next_slot(head_q);
              count_d = count_q - cnt_t'(1);
            end
            KIND_LIST: begin
              out_d.status      = ST_LISTED;
              out_d.last_result = (rem_q == cnt_t'(1));
              rem_d       = rem_q - cnt_t'(1);
              mem_re_o    = (rem_q != cnt_t'(1));
              mem_raddr_o = slot_q;
              slot_d      = next_slot(slot_q);
            end
            KIND_DELIVER: begin
              head_d  = next_slot(head_q);
              count_d = count_q - cnt_t'(1);
              if (hit) begin
                out_d.status = ST_DELIVERED;
              end else begin
                out_d.status      = ST_EXPIRED;
                out_d.last_result = 1'b0;
                resp_d            = ST_NONE_LEFT;
                mem_re_o          = (count_q != cnt_t'(1));
                mem_raddr_o       = next_slot(head_q);
              end
            end
            default: out_d.status = ST_HEAD;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    slot_q <= slot_d;
    rem_q  <= rem_d;
    resp_q <= resp_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hdl/deadline_fifo_queue.sv
`timescale 1ns / 1ps
// Deadline FIFO queue: entry store plus sequencer. Depends on dfq_pkg, dfq_mem, dfq_ctrl.
// The entry memory is read at the accepting edge; the first result is registered from S_EVAL
// or S_RESP once the output is free, and out_valid_o rises with it.
// List and deliver then emit one result per cycle while the output is not stalled; the input
// stays stalled until the last result of the word has been registered.
// Reset clears pointers, entry count and output valid; the memory is not cleared.
module deadline_fifo_queue #(
  parameter int unsigned DEPTH = dfq_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dfq_pkg::dfq_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dfq_pkg::dfq_out_t out_word_o
);
  import dfq_pkg::*;

  logic                     mem_we, mem_re;
  logic [$clog2(DEPTH)-1:0] mem_waddr, mem_raddr;
  dfq_entry_t               mem_wdata, mem_rdata;

  dfq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dfq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> hdl/dfq_checker.sv
`timescale 1ns / 1ps
// dfq_checker: port-level assertions for deadline_fifo_queue, bound to the top level.
// Depends on dfq_pkg.
module dfq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input dfq_pkg::dfq_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dfq_pkg::dfq_out_t out_word_o
);
  import dfq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_word_i.kind == KIND_PUSH || in_word_i.kind == KIND_POP ||
     in_word_i.kind == KIND_PEEK || in_word_i.kind == KIND_LIST ||
     in_word_i.kind == KIND_DELIVER) |=> in_stall_o)
    else $error("input not stalled while a word is in progress");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_ADDED || out_word_o.status == ST_FULL ||
      out_word_o.status == ST_EMPTY || out_word_o.status == ST_POPPED ||
      out_word_o.status == ST_HEAD || out_word_o.status == ST_DELIVERED ||
      out_word_o.status == ST_NONE_LEFT) |-> out_word_o.last_result)
    else $error("final-only status without last flag");

  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_EXPIRED |-> !out_word_o.last_result)
    else $error("expired result flagged last");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_EMPTY || out_word_o.status == ST_NONE_LEFT)
    |-> out_word_o.out_id == '0 && out_word_o.out_destination == '0 &&
        out_word_o.out_start == '0 && out_word_o.out_end == '0)
    else $error("empty or none-left result carries entry data");

endmodule

bind deadline_fifo_queue dfq_checker u_dfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
